// ----- src/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Field widths, register codes, the queue size and the reciprocal table used
// to divide the window sum by K*K.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int FS_W       = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [FS_W-1:0] FS_RESET  = 3'd3;
  localparam logic [FW_W-1:0] FW_RESET  = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET  = 13'd480;
  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // sum / (K*K) == (sum * ceil(2^24 / (K*K))) >> 24, exact for sums below 2^16
  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_SIZE     = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } bmf_reg_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [FS_W-1:0] k;
    logic [1:0]      b;   // half window, side is 2*b+1
    logic [FW_W-1:0] w;
    logic [FH_W-1:0] h;
  } bmf_cfg_t;

  // per-pixel classification made by the front
  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } bmf_tag_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [FS_W-1:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      3'd2:    m = 25'd4194304;
      3'd3:    m = 25'd1864136;
      3'd4:    m = 25'd1048576;
      3'd5:    m = 25'd671089;
      3'd6:    m = 25'd466034;
      3'd7:    m = 25'd342393;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// ----- src/bmf_front.sv -----
// ----------------------------------------------------------------------------
// bmf_front: raster counters, line store and window column assembly
// Accepts pixels, classifies them, and pushes one window column per pixel.
// ----------------------------------------------------------------------------
module bmf_front import bmf_pkg::*; #(
  parameter int MAX_K     = 7,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bmf_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_W-1:0]         pixel,
  input  logic                     start_of_frame,
  input  logic [QCNT_W-1:0]        q_count,
  output logic                     push,
  output bmf_tag_t                 push_tag,
  output logic [MAX_K*PIX_W-1:0]   push_col
);

  localparam int STORE_ROWS = MAX_K - 1;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int SLW        = $clog2(STORE_ROWS);
  localparam int XW         = ((CW > FW_W) ? CW : FW_W) + 1;
  localparam int LANES_W    = STORE_ROWS * PIX_W;

  logic [CW-1:0]    col_count, col_next;
  logic [ROW_W-1:0] row_count, row_next;
  logic [SLW-1:0]   slot, slot_next;

  logic [CW-1:0]    c;
  logic [ROW_W-1:0] r;
  logic [SLW-1:0]   rs;
  logic [XW-1:0]    cx, wx;
  logic [FH_W-1:0]  rx;
  logic [2:0]       two_b;
  logic             accept;
  bmf_tag_t         tag;

  logic [LANES_W-1:0] store [MAX_WIDTH];
  logic [LANES_W-1:0] rd_word;

  logic               f1_valid;
  bmf_tag_t           f1_tag;
  logic [PIX_W-1:0]   f1_pixel;
  logic [SLW-1:0]     f1_slot;

  // room for the pixel in F1 and the one accepted now
  assign in_stall = ({1'b0, q_count} + (QCNT_W+1)'(f1_valid)) >= (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    c     = start_of_frame ? '0 : col_count;
    r     = start_of_frame ? '0 : row_count;
    rs    = start_of_frame ? '0 : slot;
    cx    = XW'(c);
    wx    = XW'(cfg.w);
    rx    = FH_W'(r);
    two_b = {cfg.b, 1'b0};

    tag.emit = (rx < cfg.h) && (cx < wx) && (rx >= FH_W'(two_b)) && (cx >= XW'(two_b));
    tag.row  = ROW_W'(rx - FH_W'(cfg.b));
    tag.col  = COL_W'(cx - XW'(cfg.b));
    tag.done = (rx == cfg.h - FH_W'(1)) && (cx == wx - XW'(1));

    if (cx + XW'(1) >= wx) begin
      col_next = '0;
      if (rx + FH_W'(1) >= cfg.h) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = r + ROW_W'(1);
        slot_next = (rs == SLW'(STORE_ROWS - 1)) ? '0 : rs + SLW'(1);
      end
    end else begin
      col_next  = c + CW'(1);
      row_next  = r;
      slot_next = rs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      slot      <= '0;
      f1_valid  <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
        slot      <= slot_next;
      end
    end
  end

  // line store: one word per column, one byte lane per stored row;
  // the read returns the word as it was before this write
  always_ff @(posedge clk) begin
    if (accept) begin
      store[c][rs*PIX_W +: PIX_W] <= pixel;
      rd_word                     <= store[c];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_tag   <= tag;
      f1_pixel <= pixel;
      f1_slot  <= rs;
    end
  end

  // column: bottom entry is the new pixel, entry above holds row r-d
  always_comb begin
    logic [SLW-1:0] sl;
    sl = '0;
    push_col[(MAX_K-1)*PIX_W +: PIX_W] = f1_pixel;
    for (int d = 1; d < MAX_K; d++) begin
      if (int'(f1_slot) >= d) sl = SLW'(int'(f1_slot) - d);
      else                    sl = SLW'(int'(f1_slot) + STORE_ROWS - d);
      push_col[(MAX_K-1-d)*PIX_W +: PIX_W] = rd_word[sl*PIX_W +: PIX_W];
    end
  end

  assign push     = f1_valid;
  assign push_tag = f1_tag;

endmodule

// ----- src/bmf_queue.sv -----
// ----------------------------------------------------------------------------
// bmf_queue: small first-word-fall-through queue
// Decouples the front from the back; holds whole window columns with tags.
// ----------------------------------------------------------------------------
module bmf_queue import bmf_pkg::*; #(
  parameter int DW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DW-1:0]     push_data,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DW-1:0]     pop_data,
  output logic [QCNT_W-1:0] count
);

  logic [DW-1:0]     mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- src/bmf_back.sv -----
// ----------------------------------------------------------------------------
// bmf_back: window registers, window sum and division by K*K
// Shifts one column per queue entry, sums the active window in a registered
// tree and scales by a reciprocal; the last stage is the output register.
// ----------------------------------------------------------------------------
module bmf_back import bmf_pkg::*; #(
  parameter int MAX_K = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bmf_cfg_t               cfg,
  input  logic                   q_valid,
  input  bmf_tag_t               q_tag,
  input  logic [MAX_K*PIX_W-1:0] q_col,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       mean_value,
  output bmf_tag_t               out_tag
);

  localparam int RS_W  = $clog2(MAX_K * PIX_MAX + 1);
  localparam int SUM_W = $clog2(MAX_K * MAX_K * PIX_MAX + 1);
  localparam int PRD_W = SUM_W + RECIP_W;

  logic               adv;
  logic [PIX_W-1:0]   win [MAX_K][MAX_K];
  logic [RS_W-1:0]    row_sum [MAX_K];
  logic [SUM_W-1:0]   b3_sum;
  logic [RECIP_W-1:0] recip;
  logic [PRD_W-1:0]   b4_prod;
  logic               b1_valid, b2_valid, b3_valid, b4_valid;
  bmf_tag_t           b1_tag, b2_tag, b3_tag, b4_tag;
  int                 first;

  assign adv   = !(b4_valid && out_stall);
  assign q_pop = q_valid && adv;
  assign first = MAX_K - (2 * int'(cfg.b) + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
    end else if (adv) begin
      b1_valid <= q_valid;
      b2_valid <= b1_valid && b1_tag.emit;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    recip <= recip_of(cfg.k);
    if (adv) begin
      if (q_valid) begin
        for (int i = 0; i < MAX_K; i++) begin
          for (int j = 0; j < MAX_K - 1; j++) win[i][j] <= win[i][j+1];
          win[i][MAX_K-1] <= q_col[i*PIX_W +: PIX_W];
        end
      end
      b1_tag <= q_tag;

      // per-row sums over the active columns
      for (int i = 0; i < MAX_K; i++) begin
        logic [RS_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < MAX_K; j++)
          if (j >= first) acc = acc + RS_W'(win[i][j]);
        row_sum[i] <= acc;
      end
      b2_tag <= b1_tag;

      begin
        logic [SUM_W-1:0] tot;
        tot = '0;
        for (int i = 0; i < MAX_K; i++)
          if (i >= first) tot = tot + SUM_W'(row_sum[i]);
        b3_sum <= tot;
      end
      b3_tag <= b2_tag;

      b4_prod <= PRD_W'(b3_sum) * PRD_W'(recip);
      b4_tag  <= b3_tag;
    end
  end

  assign out_valid  = b4_valid;
  assign mean_value = b4_prod[RECIP_SH +: PIX_W];
  assign out_tag    = b4_tag;

endmodule

// ----- src/box_mean_filter.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter: streaming K x K box mean over 8-bit raster frames
// Path: front register, queue, then the back's window, row-sum, total and
// product registers. Throughput: one pixel per cycle while in_stall is low; the
// single-port line store (one read and one byte write per pixel) sets that.
// Reset: counters, queue and pipeline valids clear; registers return to
// K=3, 640x480. The line store is not cleared.
// ----------------------------------------------------------------------------
module box_mean_filter import bmf_pkg::*; #(
  parameter int MAX_K     = 7,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  start_of_frame,
  // filtered output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      mean_value,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  frame_done
);

  localparam int QDW = $bits(bmf_tag_t) + MAX_K * PIX_W;

  // Configuration registers. Writes are taken every cycle; the user only
  // writes while no transaction is in flight.
  logic [FS_W-1:0] win_size;
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  bmf_cfg_t        eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size     <= FS_RESET;
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN_SIZE:     win_size     <= cfg_data[FS_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers: zero means one, and sizes saturate at what the
  // storage was built for. b is the half window, the side is 2*b+1, so an
  // even K uses the next smaller odd window but still divides by K*K.
  always_comb begin
    if (win_size == '0)               eff.k = FS_W'(1);
    else if (int'(win_size) > MAX_K)  eff.k = FS_W'(MAX_K);
    else                              eff.k = win_size;
    eff.b = 2'((eff.k - FS_W'(1)) >> 1);

    if (frame_width == '0)               eff.w = FW_W'(1);
    else if (int'(frame_width) > MAX_WIDTH) eff.w = FW_W'(MAX_WIDTH);
    else                                 eff.w = frame_width;

    if (frame_height == '0)             eff.h = FH_W'(1);
    else if (frame_height > MAX_HEIGHT) eff.h = MAX_HEIGHT;
    else                                eff.h = frame_height;
  end

  // Front: raster position, line store access and column build-up.
  logic                   push;
  bmf_tag_t               push_tag;
  logic [MAX_K*PIX_W-1:0] push_col;
  logic [QCNT_W-1:0]      q_count;

  bmf_front #(
    .MAX_K     (MAX_K),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (eff),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .start_of_frame (start_of_frame),
    .q_count        (q_count),
    .push           (push),
    .push_tag       (push_tag),
    .push_col       (push_col)
  );

  // Queue: one entry per accepted pixel (tag plus full window column).
  logic                   q_pop, q_valid;
  logic [QDW-1:0]         q_data;
  bmf_tag_t               q_tag;
  logic [MAX_K*PIX_W-1:0] q_col;

  bmf_queue #(
    .DW (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_tag, push_col}),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign {q_tag, q_col} = q_data;

  // Back: window shift, sum tree, reciprocal multiply, output register.
  bmf_tag_t out_tag;

  bmf_back #(
    .MAX_K (MAX_K)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (eff),
    .q_valid    (q_valid),
    .q_tag      (q_tag),
    .q_col      (q_col),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_value (mean_value),
    .out_tag    (out_tag)
  );

  assign out_row    = out_tag.row;
  assign out_col    = out_tag.col;
  assign frame_done = out_tag.done;

  // The front's stall keeps the queue from overrunning.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue holds more entries than its depth");

  // The last result of a frame is centered b rows above the bottom edge.
  a_done_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> out_row == ROW_W'(eff.h - FH_W'(1) - FH_W'(eff.b)))
    else $error("frame_done on a result outside the last window row");

  // ...and b columns left of the right edge.
  a_done_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> out_col == COL_W'(eff.w - FW_W'(1) - FW_W'(eff.b)))
    else $error("frame_done on a result outside the last window column");

endmodule

// ----- dv/bmf_checker.sv -----
// ----------------------------------------------------------------------------
// bmf_checker: result predictor and scoreboard for the box mean filter
// Follows register writes and accepted pixels, keeps its own line store and
// window, and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module bmf_checker import bmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  start_of_frame,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIX_W-1:0]      mean_value,
  input  logic [ROW_W-1:0]      out_row,
  input  logic [COL_W-1:0]      out_col,
  input  logic                  frame_done,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen,
  output int                    frames_seen
);

  localparam int MAX_K      = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int STORE_ROWS = MAX_K - 1;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } mean_result_t;

  mean_result_t     expected_means[$];
  logic [PIX_W-1:0] line_rows [STORE_ROWS][MAX_WIDTH];
  logic [PIX_W-1:0] win [MAX_K][MAX_K];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [FS_W-1:0]  size_reg;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  // one pixel through the filter: shift window, load column, maybe emit
  task automatic predict_mean(input logic [PIX_W-1:0] px, input logic sof);
    int unsigned  k, w, h, half, side, r, c, rm, sum, i, j, d;
    mean_result_t exp_r;
    k = (size_reg == 0) ? 1 : size_reg;
    if (k > MAX_K) k = MAX_K;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg == 0) ? 1 : height_reg;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    half = (k - 1) / 2;
    side = 2 * half + 1;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r  = row_pos;
    c  = col_pos;
    rm = r % STORE_ROWS;
    for (i = 0; i < MAX_K; i++)
      for (j = 0; j + 1 < MAX_K; j++)
        win[i][j] = win[i][j+1];
    win[MAX_K-1][MAX_K-1] = px;
    for (d = 1; d < MAX_K; d++)
      win[MAX_K-1-d][MAX_K-1] = (c < MAX_WIDTH) ?
        line_rows[(rm + STORE_ROWS - d) % STORE_ROWS][c] : '0;
    if (c < MAX_WIDTH) line_rows[rm][c] = px;
    if (r < h && c < w && r >= 2 * half && c >= 2 * half) begin
      sum = 0;
      for (i = MAX_K - side; i < MAX_K; i++)
        for (j = MAX_K - side; j < MAX_K; j++)
          sum += win[i][j];
      exp_r.mean = PIX_W'(sum / (k * k));
      exp_r.row  = ROW_W'(r - half);
      exp_r.col  = COL_W'(c - half);
      exp_r.done = (r == h - 1) && (c == w - 1);
      expected_means.insert(expected_means.size(), exp_r);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    mean_result_t want;
    if (rst) begin
      expected_means.delete();
      for (int i = 0; i < MAX_K; i++)
        for (int j = 0; j < MAX_K; j++)
          win[i][j] = '0;
      for (int i = 0; i < STORE_ROWS; i++)
        for (int j = 0; j < MAX_WIDTH; j++)
          line_rows[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      size_reg   = FS_RESET;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      outstanding = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (frame_done) frames_seen++;
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d) mean %0d with none expected",
                                    out_row, out_col, mean_value));
        end else begin
          want = expected_means.pop_front();
          if (mean_value !== want.mean)
            report_mismatch($sformatf("mean_value at (%0d,%0d): got %0d, want %0d",
                                      want.row, want.col, mean_value, want.mean));
          if (out_row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, want %0d", out_row, want.row));
          if (out_col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, want %0d", out_col, want.col));
          if (frame_done !== want.done)
            report_mismatch($sformatf("frame_done at (%0d,%0d): got %0b, want %0b",
                                      want.row, want.col, frame_done, want.done));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIN_SIZE:     size_reg   = cfg_data[FS_W-1:0];
          REG_FRAME_WIDTH:  width_reg  = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_mean(pixel, start_of_frame);
      outstanding = expected_means.size();
    end
  end

endmodule

// ----- dv/tb_box_mean_filter.sv -----
// ----------------------------------------------------------------------------
// tb_box_mean_filter: self-checking bench for the box mean filter
// Drives register settings and raster pixel streams with random idle bursts
// on both channels; a checker beside the block predicts every result and
// scores it. This module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_box_mean_filter;
  import bmf_pkg::*;

  localparam int LATENCY      = 5;      // pixel-to-result latency of the block
  localparam int RANDOM_ITEMS = 1250;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel;
  logic                  start_of_frame;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      mean_value;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  frame_done;

  int mismatches, outstanding, results_seen, frames_seen;

  // stimulus knobs, changed per phase
  int          idle_pct  = 0;     // chance of an input gap before a pixel
  int          stall_pct = 0;     // chance of a stall burst on the output
  bit          calm      = 1'b0;  // end of run: no gaps, no stalls
  int          stall_left;
  int          pixels_sent = 0;
  int          settings    = 0;
  int unsigned cur_w, cur_h;

  box_mean_filter u_top (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pixel, .start_of_frame,
    .out_valid, .out_stall, .mean_value, .out_row, .out_col, .frame_done
  );

  bmf_checker u_checker (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pixel, .start_of_frame,
    .out_valid, .out_stall, .mean_value, .out_row, .out_col, .frame_done,
    .mismatches, .outstanding, .results_seen, .frames_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output back-pressure: random stall bursts, none when calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 18);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Global watchdog; the slowest correct run is far below this.
  initial begin
    #(20_000_000);
    $display("timeout: run did not complete");
    $display("Mismatches found");
    $finish;
  end

  // One pixel transaction, optionally preceded by an idle burst. Valid is
  // left high on return so back-to-back pixels never toggle it in one step.
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic sof);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel          <= px;
    start_of_frame <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Sender holds off until every predicted result is out, then allows the
  // pipeline latency to pass so pixels without results have cleared too.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input bmf_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic apply_config(input int unsigned k, input int unsigned w,
                              input int unsigned h);
    drain_block();
    write_reg(REG_WIN_SIZE,     CFG_DATA_W'(FS_W'(k)));
    write_reg(REG_FRAME_WIDTH,  CFG_DATA_W'(FW_W'(w)));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(FH_W'(h)));
    cfg_valid <= 1'b0;
    cur_w = FW_W'(w);
    cur_h = FH_W'(h);
    settings++;
  endtask

  // Whole frames of random pixels at the current setting. Frames after the
  // first may lack the start mark (counting alone), a stray start mark now
  // and then forces a resync, and with may_cut a frame can end early.
  task automatic stream_frames(input int n_frames, input bit mark_first,
                               input bit may_cut);
    int fw, fh, stop_at, f, p;
    logic sof;
    logic [PIX_W-1:0] px;
    fw = (cur_w == 0) ? 1 : ((cur_w > 1024) ? 1024 : cur_w);
    fh = (cur_h == 0) ? 1 : ((cur_h > 4096) ? 4096 : cur_h);
    for (f = 0; f < n_frames; f++) begin
      stop_at = fw * fh;
      if (may_cut && $urandom_range(0, 9) == 0) stop_at = $urandom_range(1, fw * fh);
      for (p = 0; p < stop_at; p++) begin
        if (p == 0) sof = (f == 0) ? mark_first : 1'($urandom_range(0, 1));
        else        sof = ($urandom_range(0, 199) == 0);
        case ($urandom_range(0, 9))
          0:       px = 8'h00;
          1:       px = 8'hFF;
          default: px = 8'($urandom);
        endcase
        if (!calm && $urandom_range(0, 299) == 0) drain_block();
        push_pixel(px, sof);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned k, w, h, half, side;
    int          start_count;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_WIN_SIZE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    pixel          = '0;
    start_of_frame = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // full-scale 3x3 window: the largest possible sum, one result, frame end
    apply_config(3, 3, 3);
    push_pixel(8'hFF, 1'b1);
    repeat (8) push_pixel(8'hFF, 1'b0);

    // size zero behaves as 1, width zero as 1: each pixel is its own result
    apply_config(0, 0, 2);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);

    // K=2: side 1, divisor 4; the second frame follows by counting alone
    apply_config(2, 2, 1);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);

    // K=7 on a 3x3 frame has no interior: nothing may come out
    apply_config(7, 3, 3);
    push_pixel(8'h5A, 1'b1);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'h3C, 1'b0);

    // frame shrinks under a running frame: the pixel beyond the new bounds
    // gives nothing and the counters wrap to a fresh frame
    apply_config(1, 4, 4);
    push_pixel(8'd12, 1'b1);
    push_pixel(8'd200, 1'b0);
    apply_config(1, 1, 1);
    push_pixel(8'd77, 1'b0);
    push_pixel(8'd99, 1'b0);

    // ---- random part: small frames, every window size ----
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      if (pixels_sent - start_count >= RANDOM_ITEMS * 9 / 10) calm = 1'b1;
      k    = $urandom_range(0, 7);
      half = (k <= 2) ? 0 : (k - 1) / 2;
      side = 2 * half + 1;
      // mostly frames with an interior, sometimes too small to have one
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, side) :
                                        $urandom_range(side, side + 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, side) :
                                        $urandom_range(side, side + 5);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 5;
        default: stall_pct = 15;
      endcase
      apply_config(k, w, h);
      stream_frames($urandom_range(1, 2), 1'b1, 1'b1);
    end

    drain_block();
    $display("Sent %0d pixels over %0d register settings (window sizes 0-7, edge widths/heights).",
             pixels_sent, settings);
    $display("Checked %0d results, %0d of them frame ends.", results_seen, frames_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
